// ----- rtl/core/dpjq_pkg.sv -----
// Shared types, codes and constants of the deduplicating priority job queue.
`timescale 1ns / 1ps
`default_nettype none

package dpjq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 32;
  localparam int CANCEL_DEPTH_DEF = 32;

  localparam int ID_W    = 31;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 6;
  localparam int LIMIT_W = 6;

  localparam logic [LIMIT_W-1:0] JOB_LIMIT_RESET = 6'd20;

  typedef enum logic [2:0] {
    CODE_APPENDED      = 3'd0,
    CODE_EVICTED       = 3'd1,
    CODE_PRIO_LOWERED  = 3'd2,
    CODE_DUP_KEPT      = 3'd3,
    CODE_INVALID       = 3'd4,
    CODE_TAKEN         = 3'd5,
    CODE_CANCEL_NOTICE = 3'd6,
    CODE_ALL_DONE      = 3'd7
  } rsp_code_t;

  localparam logic FUNC_SCHEDULE = 1'b0;
  localparam logic FUNC_TAKE     = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   job_id;
    logic [PRIO_W-1:0] job_priority;
  } req_t;

  typedef struct packed {
    rsp_code_t          code;
    logic [ID_W-1:0]    out_id;
    logic [PRIO_W-1:0]  out_priority;
    logic [COUNT_W-1:0] queued_count;
    logic               cancel_overflow;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/dpjq_if.sv -----
// Valid/ready channel interfaces for job requests and their results.
`timescale 1ns / 1ps
`default_nettype none

interface dpjq_req_if;
  logic          valid;
  logic          ready;
  dpjq_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dpjq_rsp_if;
  logic          valid;
  logic          ready;
  dpjq_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dpjq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dpjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dedup_priority_job_queue.sv -----
// Top level of the deduplicating priority job queue with its list sequencer.
//
//   channel | dir | handshake        | contents
//   req     | in  | valid/ready      | func, job_id, job_priority
//   rsp     | out | valid/ready      | code, out_id, out_priority, queued_count,
//           |     |                  | cancel_overflow
//   cfg     | in  | cfg_we only      | job_limit
//
// One request is worked on at a time; each list walk reads one RAM entry per cycle
// through a single compare unit, and removals move one entry per cycle.
// Reset is synchronous and empties both lists at once; no clearing pass is needed.
// A result waits in the output register; a new request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module dedup_priority_job_queue #(
  parameter int QUEUE_DEPTH  = dpjq_pkg::QUEUE_DEPTH_DEF,
  parameter int CANCEL_DEPTH = dpjq_pkg::CANCEL_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [dpjq_pkg::LIMIT_W-1:0] cfg_wdata,
  dpjq_req_if.sink                          req,
  dpjq_rsp_if.source                        rsp
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int CCW = $clog2(CANCEL_DEPTH + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int CAW = $clog2(CANCEL_DEPTH);
  localparam int MAXD = (QUEUE_DEPTH > CANCEL_DEPTH) ? QUEUE_DEPTH : CANCEL_DEPTH;
  localparam int IW = $clog2(MAXD + 2);
  localparam int QW = $bits(dpjq_pkg::q_entry_t);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_QSCAN   = 13'b0000000000010,
    S_LOWER   = 13'b0000000000100,
    S_QSHIFT  = 13'b0000000001000,
    S_CEVICT  = 13'b0000000010000,
    S_CPUSH   = 13'b0000000100000,
    S_QAPPEND = 13'b0000001000000,
    S_CSCAN   = 13'b0000010000000,
    S_CSHIFT  = 13'b0000100000000,
    S_TSCAN   = 13'b0001000000000,
    S_CPOP    = 13'b0010000000000,
    S_CPOPD   = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t                            state;
  dpjq_pkg::req_t                    key;
  logic [dpjq_pkg::LIMIT_W-1:0]      job_limit;
  logic [QCW-1:0]                    qcount;
  logic [CCW-1:0]                    ccount;
  logic [IW-1:0]                     idx;
  logic [IW-1:0]                     p_idx;
  logic                              p_valid;
  logic [IW-1:0]                     sel;
  logic [dpjq_pkg::PRIO_W-1:0]       fprio;
  logic [dpjq_pkg::ID_W-1:0]         evict_id;
  logic                              cshift_push;
  dpjq_pkg::rsp_code_t               res_code;
  logic [dpjq_pkg::ID_W-1:0]         res_id;
  logic [dpjq_pkg::PRIO_W-1:0]       res_prio;
  logic                              res_ovf;
  logic                              rsp_valid;
  dpjq_pkg::rsp_t                    rsp_payload;

  logic                              q_we;
  logic [QAW-1:0]                    q_waddr;
  dpjq_pkg::q_entry_t                q_wdata;
  logic [QW-1:0]                     q_rdata_raw;
  dpjq_pkg::q_entry_t                q_rd;
  logic                              c_we;
  logic [CAW-1:0]                    c_waddr;
  logic [dpjq_pkg::ID_W-1:0]         c_wdata;
  logic [dpjq_pkg::ID_W-1:0]         c_rd;

  logic                              scanning;
  logic [IW-1:0]                     lim_cur;
  logic                              issue;
  logic                              walk_done;
  logic [IW-1:0]                     pm1;
  logic [QCW-1:0]                    eff_lim;

  assign q_rd = dpjq_pkg::q_entry_t'(q_rdata_raw);
  assign pm1  = p_idx - IW'(1);

  always_comb begin
    if (job_limit == '0) begin
      eff_lim = QCW'(1);
    end else if (32'(job_limit) > QUEUE_DEPTH) begin
      eff_lim = QCW'(QUEUE_DEPTH);
    end else begin
      eff_lim = QCW'(job_limit);
    end
  end

  always_comb begin
    scanning = 1'b0;
    lim_cur  = IW'(qcount);
    unique case (state)
      S_QSCAN, S_TSCAN, S_QSHIFT: begin
        scanning = 1'b1;
        lim_cur  = IW'(qcount);
      end
      S_CSCAN, S_CSHIFT: begin
        scanning = 1'b1;
        lim_cur  = IW'(ccount);
      end
      default: begin
        scanning = 1'b0;
      end
    endcase
  end

  assign issue     = scanning && (idx < lim_cur);
  assign walk_done = !p_valid && !issue;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = pm1[QAW-1:0];
    q_wdata = q_rd;
    c_we    = 1'b0;
    c_waddr = pm1[CAW-1:0];
    c_wdata = c_rd;
    unique case (state)
      S_LOWER: begin
        if (key.job_priority < fprio) begin
          q_we    = 1'b1;
          q_waddr = sel[QAW-1:0];
          q_wdata = '{id: key.job_id, prio: key.job_priority};
        end
      end
      S_QSHIFT: begin
        q_we = p_valid;
      end
      S_QAPPEND: begin
        q_we    = 1'b1;
        q_waddr = qcount[QAW-1:0];
        q_wdata = '{id: key.job_id, prio: key.job_priority};
      end
      S_CSHIFT: begin
        c_we = p_valid;
      end
      S_CPUSH: begin
        c_we    = 1'b1;
        c_waddr = ccount[CAW-1:0];
        c_wdata = evict_id;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  dpjq_ram #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (idx[QAW-1:0]),
    .rdata (q_rdata_raw)
  );

  dpjq_ram #(
    .WIDTH (dpjq_pkg::ID_W),
    .DEPTH (CANCEL_DEPTH)
  ) u_cancel_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (idx[CAW-1:0]),
    .rdata (c_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_limit <= dpjq_pkg::JOB_LIMIT_RESET;
      qcount    <= '0;
      ccount    <= '0;
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        job_limit <= cfg_wdata;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      p_valid <= issue;
      p_idx   <= idx;
      if (issue) begin
        idx <= idx + IW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key      <= req.payload;
            res_id   <= '0;
            res_prio <= '0;
            res_ovf  <= 1'b0;
            idx      <= '0;
            if (req.payload.func == dpjq_pkg::FUNC_SCHEDULE) begin
              if (req.payload.job_id == '0) begin
                res_code <= dpjq_pkg::CODE_INVALID;
                state    <= S_OUT;
              end else begin
                state <= S_QSCAN;
              end
            end else if (qcount != '0) begin
              state <= S_TSCAN;
            end else if (ccount != '0) begin
              idx   <= IW'(ccount) - IW'(1);
              state <= S_CPOP;
            end else begin
              res_code <= dpjq_pkg::CODE_ALL_DONE;
              state    <= S_OUT;
            end
          end
        end
        S_QSCAN: begin
          if (p_valid && (q_rd.id == key.job_id)) begin
            sel   <= p_idx;
            fprio <= q_rd.prio;
            state <= S_LOWER;
          end else begin
            if (p_valid && (p_idx == '0)) begin
              evict_id <= q_rd.id;
            end
            if (walk_done) begin
              if (qcount >= eff_lim) begin
                res_code <= dpjq_pkg::CODE_EVICTED;
                res_id   <= evict_id;
                idx      <= IW'(1);
                state    <= S_QSHIFT;
              end else begin
                res_code <= dpjq_pkg::CODE_APPENDED;
                state    <= S_QAPPEND;
              end
            end
          end
        end
        S_LOWER: begin
          if (key.job_priority < fprio) begin
            res_code <= dpjq_pkg::CODE_PRIO_LOWERED;
          end else begin
            res_code <= dpjq_pkg::CODE_DUP_KEPT;
          end
          state <= S_OUT;
        end
        S_QSHIFT: begin
          if (walk_done) begin
            qcount <= qcount - QCW'(1);
            if (key.func == dpjq_pkg::FUNC_TAKE) begin
              state <= S_OUT;
            end else begin
              state <= S_CEVICT;
            end
          end
        end
        S_CEVICT: begin
          if (32'(ccount) >= CANCEL_DEPTH) begin
            res_ovf     <= 1'b1;
            cshift_push <= 1'b1;
            idx         <= IW'(1);
            state       <= S_CSHIFT;
          end else begin
            state <= S_CPUSH;
          end
        end
        S_CPUSH: begin
          ccount <= ccount + CCW'(1);
          state  <= S_QAPPEND;
        end
        S_QAPPEND: begin
          qcount <= qcount + QCW'(1);
          idx    <= '0;
          state  <= S_CSCAN;
        end
        S_CSCAN: begin
          if (p_valid && (c_rd == key.job_id)) begin
            idx         <= p_idx + IW'(1);
            p_valid     <= 1'b0;
            cshift_push <= 1'b0;
            state       <= S_CSHIFT;
          end else if (walk_done) begin
            state <= S_OUT;
          end
        end
        S_CSHIFT: begin
          if (walk_done) begin
            ccount <= ccount - CCW'(1);
            if (cshift_push) begin
              state <= S_CPUSH;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_TSCAN: begin
          if (p_valid && ((p_idx == '0) || (q_rd.prio < res_prio))) begin
            sel      <= p_idx;
            res_id   <= q_rd.id;
            res_prio <= q_rd.prio;
          end
          if (walk_done) begin
            res_code <= dpjq_pkg::CODE_TAKEN;
            idx      <= sel + IW'(1);
            state    <= S_QSHIFT;
          end
        end
        S_CPOP: begin
          state <= S_CPOPD;
        end
        S_CPOPD: begin
          res_id   <= c_rd;
          ccount   <= ccount - CCW'(1);
          res_code <= dpjq_pkg::CODE_CANCEL_NOTICE;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_payload <= '{
              code:            res_code,
              out_id:          res_id,
              out_priority:    res_prio,
              queued_count:    dpjq_pkg::COUNT_W'(qcount),
              cancel_overflow: res_ovf
            };
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_payload;

`ifndef SYNTHESIS
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QCW'(QUEUE_DEPTH))
    else $error("queue occupancy above its depth");

  a_ccount_bound: assert property (@(posedge clk) disable iff (rst)
    ccount <= CCW'(CANCEL_DEPTH))
    else $error("cancelled list occupancy above its depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another request is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!rsp_valid || rsp.ready)) |=> (rsp.valid && req.ready))
    else $error("finished request did not reach the output register");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the deduplicating priority job queue.
`timescale 1ns / 1ps

module testbench;

  localparam int ID_W    = dpjq_pkg::ID_W;
  localparam int PRIO_W  = dpjq_pkg::PRIO_W;
  localparam int LIMIT_W = dpjq_pkg::LIMIT_W;
  localparam int COUNT_W = dpjq_pkg::COUNT_W;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int NO_LIMIT_CHANGE = -1;
  localparam int RANDOM_LIMIT    = 64;
  localparam int PHASES          = 8;
  localparam int POOL_SIZE       = 48;

  typedef struct {
    int             new_limit;
    dpjq_pkg::req_t job;
    bit             typed;
    dpjq_pkg::rsp_t want;
  } directed_row_t;

  typedef struct {
    bit             typed;
    dpjq_pkg::rsp_t want;
  } typed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic result_ready = 1'b0;

  dpjq_req_if job_req ();
  dpjq_rsp_if job_rsp ();

  assign job_rsp.ready = result_ready;

  dedup_priority_job_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (job_req),
    .rsp       (job_rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue, the cancelled list and the limit register.
  logic [ID_W-1:0]    queued_ids[$];
  logic [PRIO_W-1:0]  queued_prios[$];
  logic [ID_W-1:0]    cancelled_ids[$];
  logic [LIMIT_W-1:0] limit_setting = dpjq_pkg::JOB_LIMIT_RESET;

  dpjq_pkg::rsp_t  expected_results[$];
  typed_result_t   typed_results[$];
  directed_row_t   directed_rows[$];
  logic [ID_W-1:0] id_pool[POOL_SIZE];

  int  jobs_requested   = 0;
  int  results_received = 0;
  int  mismatches       = 0;
  int  quiet_cycles     = 0;
  int  stall_left       = 0;
  bit  idle_on          = 1'b1;

  int phase_limit[PHASES] = '{3, 1, 63, 2, 0, 32, RANDOM_LIMIT, 20};
  int phase_take[PHASES]  = '{40, 10, 30, 35, 50, 20, 45, 70};
  int phase_pool[PHASES]  = '{8, 48, 40, 16, 48, 48, 24, 12};
  int phase_items[PHASES] = '{50, 75, 60, 40, 40, 60, 55, 50};

  function automatic dpjq_pkg::rsp_t predict_result(input dpjq_pkg::req_t r);
    dpjq_pkg::rsp_t res;
    int   hit;
    int   sel;
    int   lim;
    res = '0;
    res.code = dpjq_pkg::CODE_ALL_DONE;
    if (r.func == dpjq_pkg::FUNC_SCHEDULE) begin
      if (r.job_id == '0) begin
        res.code = dpjq_pkg::CODE_INVALID;
      end else begin
        hit = -1;
        foreach (queued_ids[i]) if (hit < 0 && queued_ids[i] == r.job_id) hit = i;
        if (hit >= 0) begin
          if (r.job_priority < queued_prios[hit]) begin
            queued_prios[hit] = r.job_priority;
            res.code = dpjq_pkg::CODE_PRIO_LOWERED;
          end else begin
            res.code = dpjq_pkg::CODE_DUP_KEPT;
          end
        end else begin
          lim = (limit_setting == 0) ? 1 : int'(limit_setting);
          if (lim > dpjq_pkg::QUEUE_DEPTH_DEF) lim = dpjq_pkg::QUEUE_DEPTH_DEF;
          res.code = dpjq_pkg::CODE_APPENDED;
          if (queued_ids.size() >= lim) begin
            res.code = dpjq_pkg::CODE_EVICTED;
            res.out_id = queued_ids.pop_front();
            void'(queued_prios.pop_front());
            if (cancelled_ids.size() >= dpjq_pkg::CANCEL_DEPTH_DEF) begin
              void'(cancelled_ids.pop_front());
              res.cancel_overflow = 1'b1;
            end
            cancelled_ids.push_back(res.out_id);
          end
          queued_ids.push_back(r.job_id);
          queued_prios.push_back(r.job_priority);
          hit = -1;
          foreach (cancelled_ids[i]) if (hit < 0 && cancelled_ids[i] == r.job_id) hit = i;
          if (hit >= 0) cancelled_ids.delete(hit);
        end
      end
    end else if (queued_ids.size() > 0) begin
      sel = 0;
      foreach (queued_prios[i]) if (queued_prios[i] < queued_prios[sel]) sel = i;
      res.code = dpjq_pkg::CODE_TAKEN;
      res.out_id = queued_ids[sel];
      res.out_priority = queued_prios[sel];
      queued_ids.delete(sel);
      queued_prios.delete(sel);
    end else if (cancelled_ids.size() > 0) begin
      res.code = dpjq_pkg::CODE_CANCEL_NOTICE;
      res.out_id = cancelled_ids.pop_back();
    end
    res.queued_count = COUNT_W'(queued_ids.size());
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic dpjq_pkg::req_t random_request(input int pool, input int take_pct);
    dpjq_pkg::req_t r;
    int   roll;
    r.func = dpjq_pkg::FUNC_SCHEDULE;
    r.job_id = ID_W'($urandom());
    r.job_priority = PRIO_W'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < take_pct) begin
      r.func = dpjq_pkg::FUNC_TAKE;
    end else if (roll < take_pct + 3) begin
      r.job_id = '0;
    end else begin
      if ($urandom_range(0, 99) < 85) r.job_id = id_pool[$urandom_range(0, pool - 1)];
      else r.job_id = ID_W'($urandom_range(1, 32'h7FFF_FFFF));
      roll = $urandom_range(0, 9);
      if (roll < 3) r.job_priority = PRIO_W'($urandom_range(0, 7));
      else if (roll == 3) r.job_priority = '0;
      else if (roll == 4) r.job_priority = '1;
    end
    return r;
  endfunction

  function automatic void add_row(input int new_limit, input logic func,
                                  input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                                  input bit typed, input dpjq_pkg::rsp_code_t code,
                                  input logic [ID_W-1:0] out_id,
                                  input logic [PRIO_W-1:0] out_prio, input int count);
    directed_row_t row;
    row.new_limit = new_limit;
    row.job.func = func;
    row.job.job_id = id;
    row.job.job_priority = prio;
    row.typed = typed;
    row.want = '0;
    row.want.code = code;
    row.want.out_id = out_id;
    row.want.out_priority = out_prio;
    row.want.queued_count = COUNT_W'(count);
    directed_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string what, input dpjq_pkg::rsp_t want,
                               input dpjq_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected code %0d id %h prio %h count %0d ovf %b", $realtime, what,
               want.code, want.out_id, want.out_priority, want.queued_count,
               want.cancel_overflow);
      $display("%0t: %s:   actual code %0d id %h prio %h count %0d ovf %b", $realtime, what,
               got.code, got.out_id, got.out_priority, got.queued_count, got.cancel_overflow);
    end
  endtask

  task automatic push_request(input dpjq_pkg::req_t r, input bit typed,
                              input dpjq_pkg::rsp_t want);
    int            gap;
    typed_result_t note;
    gap = pick_gap();
    if (gap > 0) begin
      job_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    typed_results.push_back(note);
    job_req.valid <= 1'b1;
    job_req.payload <= r;
    @(posedge clk);
    while (!job_req.ready) @(posedge clk);
    jobs_requested++;
  endtask

  task automatic wait_all_results();
    while (results_received != jobs_requested) @(posedge clk);
  endtask

  task automatic set_job_limit(input logic [LIMIT_W-1:0] value);
    job_req.valid <= 1'b0;
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_setting = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      result_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    dpjq_pkg::rsp_t want;
    typed_result_t  note;
    bit             moved;
    if (!rst) begin
      moved = 1'b0;
      if (job_rsp.valid && job_rsp.ready) begin
        moved = 1'b1;
        results_received++;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, job_rsp.payload);
        end else begin
          want = expected_results.pop_front();
          if (want.code !== job_rsp.payload.code ||
              want.out_id !== job_rsp.payload.out_id ||
              want.out_priority !== job_rsp.payload.out_priority ||
              want.queued_count !== job_rsp.payload.queued_count ||
              want.cancel_overflow !== job_rsp.payload.cancel_overflow)
            note_mismatch("result mismatch", want, job_rsp.payload);
        end
      end
      if (job_req.valid && job_req.ready) begin
        moved = 1'b1;
        want = predict_result(job_req.payload);
        note = typed_results.pop_front();
        if (note.typed) want = note.want;
        expected_results.push_back(want);
      end
      if (moved) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    int            lim;
    directed_row_t row;
    job_req.valid = 1'b0;
    job_req.payload = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    id_pool[0] = 31'h7FFF_FFFF;
    id_pool[1] = 31'd1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(1, 32'h7FFF_FFFF));

    // Register at its reset value: empty lists, invalid id, dedup and ties.
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'h2AAA_AAAA, 16'h5555, 1,
            dpjq_pkg::CODE_ALL_DONE, 0, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'd0, 16'hFFFF, 1,
            dpjq_pkg::CODE_INVALID, 0, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'h7FFF_FFFF, 16'hFFFF, 1,
            dpjq_pkg::CODE_APPENDED, 0, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'h7FFF_FFFF, 16'hFFFF, 1,
            dpjq_pkg::CODE_DUP_KEPT, 0, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'h7FFF_FFFF, 16'h0000, 1,
            dpjq_pkg::CODE_PRIO_LOWERED, 0, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'd1, 16'h0000, 1,
            dpjq_pkg::CODE_APPENDED, 0, 0, 2);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'h5555_5555, 16'hAAAA, 1,
            dpjq_pkg::CODE_TAKEN, 31'h7FFF_FFFF, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 1,
            dpjq_pkg::CODE_TAKEN, 31'd1, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 1,
            dpjq_pkg::CODE_ALL_DONE, 0, 0, 0);
    // A limit of zero behaves as one: every new id evicts the previous one.
    add_row(0, dpjq_pkg::FUNC_SCHEDULE, 31'd5, 16'd7, 1,
            dpjq_pkg::CODE_APPENDED, 0, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'd6, 16'd3, 1,
            dpjq_pkg::CODE_EVICTED, 31'd5, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'd5, 16'd9, 1,
            dpjq_pkg::CODE_EVICTED, 31'd6, 0, 1);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 1,
            dpjq_pkg::CODE_TAKEN, 31'd5, 16'd9, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 1,
            dpjq_pkg::CODE_CANCEL_NOTICE, 31'd6, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 1,
            dpjq_pkg::CODE_ALL_DONE, 0, 0, 0);
    add_row(63, dpjq_pkg::FUNC_SCHEDULE, 31'h2AAA_AAAA, 16'hAAAA, 0,
            dpjq_pkg::CODE_APPENDED, 0, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_SCHEDULE, 31'h5555_5555, 16'h5555, 0,
            dpjq_pkg::CODE_APPENDED, 0, 0, 0);
    add_row(NO_LIMIT_CHANGE, dpjq_pkg::FUNC_TAKE, 31'd0, 16'd0, 0,
            dpjq_pkg::CODE_APPENDED, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.new_limit != NO_LIMIT_CHANGE) set_job_limit(LIMIT_W'(row.new_limit));
      push_request(row.job, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      lim = (phase_limit[p] == RANDOM_LIMIT) ? $urandom_range(0, 63) : phase_limit[p];
      set_job_limit(LIMIT_W'(lim));
      idle_on = (p % 3 != 2);
      repeat (phase_items[p]) push_request(random_request(phase_pool[p], phase_take[p]), 0, '0);
    end

    job_req.valid <= 1'b0;
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dpjq_pkg.sv
rtl/core/dpjq_if.sv
rtl/core/dpjq_ram.sv
rtl/core/dedup_priority_job_queue.sv
tb/testbench.sv
